// ===== src/twcc_pkg.sv =====
// ----------------------------------------------------------------------------
// twcc_pkg
// Shared types and constants for the transport-wide sequence number extractor.
// ----------------------------------------------------------------------------
package twcc_pkg;

  localparam int DataW    = 8;
  localparam int IdW      = 4;
  localparam int PosW     = 7;   // byte position, saturates well past the header
  localparam int AreaW    = 18;  // extension area bytes plus trailing bytes
  localparam int SkipW    = 5;
  localparam int SeqW     = 16;
  localparam int StatusW  = 3;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;
  localparam int FifoCntW  = FifoAw + 1;
  localparam logic [FifoCntW-1:0] FifoFull   = FifoCntW'(FifoDepth);
  localparam logic [FifoCntW-1:0] FifoCntOne = FifoCntW'(1);

  localparam logic [PosW-1:0]  PosMax      = '1;
  localparam logic [PosW-1:0]  HdrBase     = 7'd12; // profile word at 12 + 4*CC
  localparam logic [PosW-1:0]  NeedLastPos = 7'd18; // last byte of 19-byte minimum
  localparam logic [15:0]      ProfileBede = 16'hBEDE;
  localparam logic [IdW-1:0]   TwccIdReset = 4'd1;
  localparam int               ExtBit      = 4;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_WALK,
    PH_SEQ_HI,
    PH_SEQ_LO,
    PH_DONE
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND       = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_NO_EXT      = 3'd3,
    ST_BAD_PROFILE = 3'd4
  } status_t;

  // One classified packet byte as it sits in the queue.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic [PosW-1:0]  pos;
  } byte_item_t;

endpackage

// ===== src/twcc_ifs.sv =====
// ----------------------------------------------------------------------------
// twcc stream interfaces
// Valid/ready channels for packet bytes and for extraction results.
// ----------------------------------------------------------------------------
interface twcc_byte_if;
  logic                       valid;
  logic                       ready;
  logic [twcc_pkg::DataW-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface twcc_result_if;
  logic                         valid;
  logic                         ready;
  logic [twcc_pkg::StatusW-1:0] status;
  logic [twcc_pkg::SeqW-1:0]    seq_number;

  modport source (output valid, output status, output seq_number, input ready);
  modport sink   (input valid, input status, input seq_number, output ready);
endinterface

// ===== src/twcc_front.sv =====
// ----------------------------------------------------------------------------
// twcc_front
// Accepts packet bytes and tags each with its position in the packet.
// ----------------------------------------------------------------------------
module twcc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  twcc_byte_if.sink            in_bus,
  input  logic                 fifo_full,
  output logic                 push,
  output twcc_pkg::byte_item_t push_item
);

  logic [twcc_pkg::PosW-1:0] pos_r;
  logic [twcc_pkg::PosW-1:0] pos_nxt;

  assign in_bus.ready = !fifo_full;
  assign push         = in_bus.valid && in_bus.ready;

  assign push_item.data = in_bus.data_byte;
  assign push_item.last = in_bus.last_byte;
  assign push_item.pos  = pos_r;

  // Restart at the packet boundary; hold at the top once past the header.
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      if (in_bus.last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != twcc_pkg::PosMax) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== src/twcc_fifo.sv =====
// ----------------------------------------------------------------------------
// twcc_fifo
// Short queue of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
module twcc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  twcc_pkg::byte_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 item_valid,
  output twcc_pkg::byte_item_t item
);

  twcc_pkg::byte_item_t                mem_r [twcc_pkg::FifoDepth];
  logic [twcc_pkg::FifoAw-1:0]         wr_ptr_r;
  logic [twcc_pkg::FifoAw-1:0]         rd_ptr_r;
  logic [twcc_pkg::FifoCntW-1:0]       count_r;

  assign full       = (count_r == twcc_pkg::FifoFull);
  assign item_valid = (count_r != '0);
  assign item       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + twcc_pkg::FifoCntOne;
      end else if (pop && !push) begin
        count_r <= count_r - twcc_pkg::FifoCntOne;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != twcc_pkg::FifoFull))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + twcc_pkg::FifoCntOne))
    else $error("queue count did not advance on write");
`endif

endmodule

// ===== src/twcc_back.sv =====
// ----------------------------------------------------------------------------
// twcc_back
// Parses the RTP header and one-byte extension walk; registers the result.
// ----------------------------------------------------------------------------
module twcc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [twcc_pkg::IdW-1:0]   twcc_ext_id,
  input  logic                       item_valid,
  input  twcc_pkg::byte_item_t       item,
  output logic                       pop,
  twcc_result_if.source              out_bus
);

  twcc_pkg::phase_t               phase_r, phase_nxt;
  logic [3:0]                     cc_r, cc_nxt;
  logic                           ext_r, ext_nxt;
  logic [15:0]                    prof_r, prof_nxt;
  logic [twcc_pkg::AreaW-1:0]     area_r, area_nxt;
  logic [twcc_pkg::SkipW-1:0]     skip_r, skip_nxt;
  logic                           match_r, match_nxt;
  logic [twcc_pkg::SeqW-1:0]      capt_r, capt_nxt;
  logic                           given_r, given_nxt;

  logic                           out_valid_r;
  twcc_pkg::status_t              out_status_r;
  logic [twcc_pkg::SeqW-1:0]      out_seq_r;

  logic                           emit;
  twcc_pkg::status_t              emit_status;
  logic [twcc_pkg::SeqW-1:0]      emit_seq;
  logic [twcc_pkg::PosW-1:0]      base_w;
  logic [twcc_pkg::PosW-1:0]      need_w;
  logic [twcc_pkg::AreaW-1:0]     rem_w;
  logic [twcc_pkg::SkipW-1:0]     elem_len;

  // Take a byte whenever the result register is free or draining.
  assign pop = item_valid && (!out_valid_r || out_bus.ready);

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.seq_number = out_seq_r;

  always_comb begin
    phase_nxt   = phase_r;
    cc_nxt      = cc_r;
    ext_nxt     = ext_r;
    prof_nxt    = prof_r;
    area_nxt    = area_r;
    skip_nxt    = skip_r;
    match_nxt   = match_r;
    capt_nxt    = capt_r;
    given_nxt   = given_r;
    emit        = 1'b0;
    emit_status = twcc_pkg::ST_TOO_SHORT;
    emit_seq    = '0;
    base_w      = '0;
    need_w      = '0;
    rem_w       = area_r - twcc_pkg::AreaW'(4);
    elem_len    = {1'b0, item.data[3:0]} + 5'd1;

    if (pop && !given_r) begin
      if (phase_r == twcc_pkg::PH_HEAD) begin
        if (item.pos == '0) begin
          ext_nxt = item.data[twcc_pkg::ExtBit];
          cc_nxt  = item.data[3:0];
        end
        base_w = twcc_pkg::HdrBase + {1'b0, cc_nxt, 2'b00};
        if (item.pos == base_w) begin
          prof_nxt = {8'h00, item.data};
        end else if (item.pos == base_w + 7'd1) begin
          prof_nxt = {prof_r[7:0], item.data};
        end else if (item.pos == base_w + 7'd2) begin
          area_nxt = {10'd0, item.data};
        end else if (item.pos == base_w + 7'd3) begin
          // Length in words times four, plus the three bytes that follow.
          area_nxt  = {area_r[7:0], item.data, 2'b11};
          phase_nxt = ({area_r[7:0], item.data} == 16'd0) ? twcc_pkg::PH_DONE
                                                           : twcc_pkg::PH_WALK;
        end
      end else begin
        case (phase_r)
          twcc_pkg::PH_WALK: begin
            if (area_r < twcc_pkg::AreaW'(4)) begin
              phase_nxt = twcc_pkg::PH_DONE;
            end else begin
              if (skip_r != '0) begin
                skip_nxt = skip_r - 1'b1;
              end else if (item.data != '0) begin
                if (item.data[7:4] == twcc_ext_id) begin
                  phase_nxt = twcc_pkg::PH_SEQ_HI;
                end else if ({13'd0, elem_len} >= rem_w) begin
                  // element runs to or past the area end
                  phase_nxt = twcc_pkg::PH_DONE;
                end else begin
                  skip_nxt = elem_len;
                end
              end
              if (phase_nxt == twcc_pkg::PH_WALK && rem_w == '0) begin
                phase_nxt = twcc_pkg::PH_DONE;
              end
            end
          end
          twcc_pkg::PH_SEQ_HI: begin
            capt_nxt  = {item.data, 8'h00};
            phase_nxt = twcc_pkg::PH_SEQ_LO;
          end
          twcc_pkg::PH_SEQ_LO: begin
            capt_nxt  = {capt_r[15:8], item.data};
            match_nxt = 1'b1;
            phase_nxt = twcc_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
        if (area_r != '0) begin
          area_nxt = area_r - 1'b1;
        end
      end

      // Status checks in priority order.
      need_w = twcc_pkg::NeedLastPos + {1'b0, cc_nxt, 2'b00};
      if (!ext_nxt) begin
        if (item.pos == twcc_pkg::NeedLastPos) begin
          emit        = 1'b1;
          emit_status = twcc_pkg::ST_NO_EXT;
        end
      end else if (item.pos == need_w && prof_nxt != twcc_pkg::ProfileBede) begin
        emit        = 1'b1;
        emit_status = twcc_pkg::ST_BAD_PROFILE;
      end else if (phase_nxt != twcc_pkg::PH_HEAD && area_nxt == '0 &&
                   item.pos >= need_w) begin
        emit = 1'b1;
        if (match_nxt) begin
          emit_status = twcc_pkg::ST_FOUND;
          emit_seq    = capt_nxt;
        end else begin
          emit_status = twcc_pkg::ST_NOT_FOUND;
        end
      end
      if (!emit && item.last) begin
        emit        = 1'b1;
        emit_status = twcc_pkg::ST_TOO_SHORT;
      end
      if (emit) begin
        given_nxt = 1'b1;
      end
    end

    // Drop all per-packet state at the packet boundary.
    if (pop && item.last) begin
      phase_nxt = twcc_pkg::PH_HEAD;
      cc_nxt    = '0;
      ext_nxt   = 1'b0;
      prof_nxt  = '0;
      area_nxt  = '0;
      skip_nxt  = '0;
      match_nxt = 1'b0;
      capt_nxt  = '0;
      given_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= twcc_pkg::PH_HEAD;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= '0;
      ext_r       <= 1'b0;
      prof_r      <= '0;
      area_r      <= '0;
      skip_r      <= '0;
      match_r     <= 1'b0;
      capt_r      <= '0;
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cc_r    <= cc_nxt;
      ext_r   <= ext_nxt;
      prof_r  <= prof_nxt;
      area_r  <= area_nxt;
      skip_r  <= skip_nxt;
      match_r <= match_nxt;
      capt_r  <= capt_nxt;
      given_r <= given_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_seq_r    <= emit_seq;
    end
  end

`ifndef SYNTH
  a_seq_hi_to_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !given_r && !item.last && phase_r == twcc_pkg::PH_SEQ_HI)
      |=> (phase_r == twcc_pkg::PH_SEQ_LO))
    else $error("high sequence byte not followed by low byte capture");

  a_match_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> (phase_r == twcc_pkg::PH_DONE))
    else $error("match recorded while walk still active");

  a_head_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == twcc_pkg::PH_HEAD) |-> (skip_r == '0 && !match_r))
    else $error("walk state left over during header");
`endif

endmodule

// ===== src/rtp_twcc_seq_extractor.sv =====
// ----------------------------------------------------------------------------
// rtp_twcc_seq_extractor
// Extracts the transport-wide sequence number from an RTP one-byte extension.
// ----------------------------------------------------------------------------
//
//   port      dir   handshake             payload
//   in_bus    in    valid/ready           data_byte[7:0], last_byte
//   out_bus   out   valid/ready           status[2:0], seq_number[15:0]
//   cfg (APB) in    psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
// One byte is accepted per cycle while the four-entry byte queue has room.
// The parser retires one queued byte per cycle whenever its result register
// is free or being taken. With an empty queue a result passes through the
// queue entry and then the result register after its deciding byte arrives.
// One result per packet; later bytes up to the last-byte mark are consumed
// and dropped. A stalled result holds the parser, and the queue then fills
// and drops in_bus.ready. Reset clears all packet state and sets
// twcc_ext_id to 1; there is no clearing pass.
//
module rtp_twcc_seq_extractor (
  input  logic                          clk,
  input  logic                          rst_n,
  twcc_byte_if.sink                     in_bus,
  twcc_result_if.source                 out_bus,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twcc_pkg::CfgAddrW-1:0] paddr,
  input  logic [twcc_pkg::CfgDataW-1:0] pwdata,
  output logic [twcc_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic [twcc_pkg::IdW-1:0] twcc_ext_id_r;
  logic                     reg_sel;

  logic                     fifo_full;
  logic                     push;
  twcc_pkg::byte_item_t     push_item;
  logic                     pop;
  logic                     item_valid;
  twcc_pkg::byte_item_t     item;

  // Only register 0 exists; byte lanes within the word are ignored.
  assign reg_sel = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (psel && reg_sel)
                 ? {{(twcc_pkg::CfgDataW - twcc_pkg::IdW){1'b0}}, twcc_ext_id_r}
                 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twcc_ext_id_r <= twcc_pkg::TwccIdReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      twcc_ext_id_r <= pwdata[twcc_pkg::IdW-1:0];
    end
  end

  // Front: accept and tag each byte with its packet position.
  twcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple input acceptance from result back-pressure.
  twcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  // Back: header parse, element walk, status decision, result register.
  twcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .twcc_ext_id (twcc_ext_id_r),
    .item_valid  (item_valid),
    .item        (item),
    .pop         (pop),
    .out_bus     (out_bus)
  );

endmodule
